// ===== design/spg_pkg.sv =====
`default_nettype none

package spg_pkg;

  localparam int MAX_LEN_DEF = 6;
  localparam int CHAR_W      = 8;
  localparam int CMD_W       = 2;
  localparam int LEN_W       = 3;
  localparam int ARR_W       = 48;
  localparam int RANK_W      = 10;
  localparam int UPC_W       = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EMIT  = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CLEAR,
    OP_LD_INIT,
    OP_LD_SHIFT,
    OP_LD_PUT,
    OP_EM_INIT,
    OP_GATHER,
    OP_ST_INIT,
    OP_ST_SCAN,
    OP_Q_INIT,
    OP_Q_SCAN,
    OP_SWAP_A,
    OP_SWAP_B,
    OP_REV_INIT,
    OP_REV_A,
    OP_REV_B,
    OP_REV_C,
    OP_FIN_OK,
    OP_FIN_LAST,
    OP_FIN_BAD
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_TAKE,
    C_CMD_CLEAR,
    C_CMD_LOAD,
    C_CMD_EMIT,
    C_FULL,
    C_INS_MOVE,
    C_NOT_READY,
    C_GATHER_MORE,
    C_N_LT2,
    C_P_ZERO,
    C_SCAN_CONT,
    C_Q_CONT,
    C_LO_GE_HI,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             ret;
  } ucode_t;

  typedef struct packed {
    logic no_take;
    logic cmd_clear;
    logic cmd_load;
    logic cmd_emit;
    logic full;
    logic ins_move;
    logic not_ready;
    logic gather_more;
    logic n_lt2;
    logic p_zero;
    logic scan_cont;
    logic q_cont;
    logic lo_ge_hi;
    logic out_busy;
  } spg_flags_t;

  // microprogram labels
  localparam logic [UPC_W-1:0] U_IDLE = 5'd0;
  localparam logic [UPC_W-1:0] U_CLR  = 5'd5;
  localparam logic [UPC_W-1:0] U_LD0  = 5'd6;
  localparam logic [UPC_W-1:0] U_LD1  = 5'd7;
  localparam logic [UPC_W-1:0] U_EM0  = 5'd9;
  localparam logic [UPC_W-1:0] U_EM1  = 5'd10;
  localparam logic [UPC_W-1:0] U_EM3  = 5'd12;
  localparam logic [UPC_W-1:0] U_EM6  = 5'd15;
  localparam logic [UPC_W-1:0] U_REV  = 5'd19;
  localparam logic [UPC_W-1:0] U_OK   = 5'd23;
  localparam logic [UPC_W-1:0] U_LAST = 5'd24;
  localparam logic [UPC_W-1:0] U_BAD  = 5'd25;

  function automatic ucode_t uw(input op_t op, input cond_t cond,
                                input logic [UPC_W-1:0] target, input logic ret);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.ret    = ret;
    return w;
  endfunction

  function automatic ucode_t rom_word(input logic [UPC_W-1:0] a);
    ucode_t w;
    unique case (a)
      5'd0:    w = uw(OP_ACCEPT,   C_NO_TAKE,     U_IDLE, 1'b0);
      5'd1:    w = uw(OP_NOP,      C_CMD_CLEAR,   U_CLR,  1'b0);
      5'd2:    w = uw(OP_NOP,      C_CMD_LOAD,    U_LD0,  1'b0);
      5'd3:    w = uw(OP_NOP,      C_CMD_EMIT,    U_EM0,  1'b0);
      5'd4:    w = uw(OP_NOP,      C_ALWAYS,      U_IDLE, 1'b0);
      5'd5:    w = uw(OP_CLEAR,    C_ALWAYS,      U_IDLE, 1'b0);
      5'd6:    w = uw(OP_LD_INIT,  C_FULL,        U_IDLE, 1'b0);
      5'd7:    w = uw(OP_LD_SHIFT, C_INS_MOVE,    U_LD1,  1'b0);
      5'd8:    w = uw(OP_LD_PUT,   C_ALWAYS,      U_IDLE, 1'b0);
      5'd9:    w = uw(OP_EM_INIT,  C_NOT_READY,   U_BAD,  1'b0);
      5'd10:   w = uw(OP_GATHER,   C_GATHER_MORE, U_EM1,  1'b0);
      5'd11:   w = uw(OP_ST_INIT,  C_N_LT2,       U_LAST, 1'b0);
      5'd12:   w = uw(OP_NOP,      C_P_ZERO,      U_LAST, 1'b0);
      5'd13:   w = uw(OP_ST_SCAN,  C_SCAN_CONT,   U_EM3,  1'b0);
      5'd14:   w = uw(OP_Q_INIT,   C_NEVER,       U_IDLE, 1'b0);
      5'd15:   w = uw(OP_Q_SCAN,   C_Q_CONT,      U_EM6,  1'b0);
      5'd16:   w = uw(OP_SWAP_A,   C_NEVER,       U_IDLE, 1'b0);
      5'd17:   w = uw(OP_SWAP_B,   C_NEVER,       U_IDLE, 1'b0);
      5'd18:   w = uw(OP_REV_INIT, C_NEVER,       U_IDLE, 1'b0);
      5'd19:   w = uw(OP_NOP,      C_LO_GE_HI,    U_OK,   1'b0);
      5'd20:   w = uw(OP_REV_A,    C_NEVER,       U_IDLE, 1'b0);
      5'd21:   w = uw(OP_REV_B,    C_NEVER,       U_IDLE, 1'b0);
      5'd22:   w = uw(OP_REV_C,    C_ALWAYS,      U_REV,  1'b0);
      5'd23:   w = uw(OP_FIN_OK,   C_OUT_BUSY,    U_OK,   1'b1);
      5'd24:   w = uw(OP_FIN_LAST, C_OUT_BUSY,    U_LAST, 1'b1);
      5'd25:   w = uw(OP_FIN_BAD,  C_OUT_BUSY,    U_BAD,  1'b1);
      default: w = uw(OP_NOP,      C_ALWAYS,      U_IDLE, 1'b0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/sorted_permutation_generator_core.sv =====
// Sorted permutation generator. Characters are loaded one per transaction
// (command load) and kept in ascending order by insertion; once string_length
// characters are in, each emit transaction returns the next arrangement in
// lexicographic order together with its rank and a last flag, and a clear
// transaction starts over. Equal characters are treated as distinct, so all
// L! arrangements appear. Only emit produces a result. A small microprogram
// runs one item at a time over index registers with a single read port, one
// register access per step: a load shifts each larger character up by one
// place before placing the new one, and a valid emit gathers the
// arrangement, then runs the pivot scan, the swap search and the suffix
// reversal. A finished result sits in an output register, so the next
// transaction is taken while it waits.
`default_nettype none

module sorted_permutation_generator_core #(
  parameter int MAX_LEN = spg_pkg::MAX_LEN_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_wr_en,
  input  wire  [spg_pkg::LEN_W-1:0]    cfg_wr_data,
  input  wire                          cmd_valid,
  output logic                         cmd_ready,
  input  wire  [spg_pkg::CMD_W-1:0]    command,
  input  wire  [spg_pkg::CHAR_W-1:0]   char_value,
  output logic                         res_valid,
  input  wire                          res_ready,
  output logic [spg_pkg::ARR_W-1:0]    arrangement,
  output logic [spg_pkg::RANK_W-1:0]   rank,
  output logic                         is_last,
  output logic                         valid_res
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int NW = (CW > spg_pkg::LEN_W) ? CW : spg_pkg::LEN_W;
  localparam int AW = 8 * MAX_LEN;

  spg_pkg::ucode_t    uword;
  spg_pkg::spg_flags_t flags;
  spg_pkg::op_t       op;

  logic [spg_pkg::LEN_W-1:0]  string_length;
  logic [spg_pkg::CMD_W-1:0]  cmd_q;
  logic [spg_pkg::CHAR_W-1:0] ch_q;

  logic [spg_pkg::CHAR_W-1:0] chars [MAX_LEN];
  logic [IW-1:0]              idx_ord [MAX_LEN];
  logic [CW-1:0]              loaded;
  logic [spg_pkg::RANK_W-1:0] emitted;
  logic                       exhausted;

  logic [CW-1:0] ptr, p, q, lo, hi;
  logic [IW-1:0] b_val, piv, tmp;
  logic [AW-1:0] arr;

  logic [NW-1:0] len_ext, n_wide;
  logic [CW-1:0] n, nm1, pm1, ptrm1, ptr_inc;
  logic [IW-1:0] raddr, craddr, iw_addr, iw_data;
  logic          iw_en;
  logic [IW-1:0] idx_rd;
  logic [spg_pkg::CHAR_W-1:0] crd;
  logic          restart, out_busy, fin_go;
  logic [AW+spg_pkg::ARR_W-1:0] arr_ext;

  spg_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uword (uword)
  );

  assign op = uword.op;

  // effective length, clamped to 1..MAX_LEN
  always_comb begin
    len_ext = NW'(string_length);
    if (len_ext == '0) begin
      n_wide = NW'(1);
    end else if (len_ext > NW'(MAX_LEN)) begin
      n_wide = NW'(MAX_LEN);
    end else begin
      n_wide = len_ext;
    end
  end

  assign n       = n_wide[CW-1:0];
  assign nm1     = n - 1'b1;
  assign pm1     = p - 1'b1;
  assign ptrm1   = ptr - 1'b1;
  assign ptr_inc = ptr + 1'b1;

  always_comb begin
    case (op) inside
      spg_pkg::OP_ST_INIT:               raddr = nm1[IW-1:0];
      spg_pkg::OP_ST_SCAN:               raddr = pm1[IW-1:0];
      spg_pkg::OP_Q_SCAN, spg_pkg::OP_SWAP_A: raddr = q[IW-1:0];
      spg_pkg::OP_REV_A:                 raddr = lo[IW-1:0];
      spg_pkg::OP_REV_B:                 raddr = hi[IW-1:0];
      default:                           raddr = ptr[IW-1:0];
    endcase
  end

  assign idx_rd = idx_ord[raddr];
  assign craddr = (op == spg_pkg::OP_GATHER) ? idx_rd : ptrm1[IW-1:0];
  assign crd    = chars[craddr];

  always_comb begin
    iw_en   = 1'b0;
    iw_addr = q[IW-1:0];
    iw_data = piv;
    case (op)
      spg_pkg::OP_SWAP_A: begin
        iw_en   = 1'b1;
        iw_addr = pm1[IW-1:0];
        iw_data = idx_rd;
      end
      spg_pkg::OP_SWAP_B: begin
        iw_en   = 1'b1;
        iw_addr = q[IW-1:0];
        iw_data = piv;
      end
      spg_pkg::OP_REV_B: begin
        iw_en   = 1'b1;
        iw_addr = lo[IW-1:0];
        iw_data = idx_rd;
      end
      spg_pkg::OP_REV_C: begin
        iw_en   = 1'b1;
        iw_addr = hi[IW-1:0];
        iw_data = tmp;
      end
      default: begin
        iw_en = 1'b0;
      end
    endcase
  end

  assign restart   = (op == spg_pkg::OP_CLEAR) || (op == spg_pkg::OP_LD_PUT);
  assign out_busy  = res_valid && !res_ready;
  assign fin_go    = !out_busy;
  assign cmd_ready = (op == spg_pkg::OP_ACCEPT);

  always_comb begin
    flags.no_take     = !cmd_valid;
    flags.cmd_clear   = (cmd_q == spg_pkg::CMD_CLEAR);
    flags.cmd_load    = (cmd_q == spg_pkg::CMD_LOAD);
    flags.cmd_emit    = (cmd_q == spg_pkg::CMD_EMIT);
    flags.full        = (loaded >= n);
    flags.ins_move    = (ptr != '0) && (crd > ch_q);
    flags.not_ready   = (loaded != n) || exhausted;
    flags.gather_more = (ptr_inc < n);
    flags.n_lt2       = (n < CW'(2));
    flags.p_zero      = (p == '0);
    flags.scan_cont   = (idx_rd >= b_val);
    flags.q_cont      = (idx_rd <= piv);
    flags.lo_ge_hi    = (lo >= hi);
    flags.out_busy    = out_busy;
  end

  // config and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      string_length <= spg_pkg::LEN_W'(1);
      loaded        <= '0;
      emitted       <= '0;
      exhausted     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        string_length <= cfg_wr_data;
      end
      if (op == spg_pkg::OP_CLEAR) begin
        loaded <= '0;
      end else if (op == spg_pkg::OP_LD_PUT) begin
        loaded <= loaded + 1'b1;
      end
      if (restart) begin
        emitted   <= '0;
        exhausted <= 1'b0;
      end else if (fin_go && op == spg_pkg::OP_FIN_OK) begin
        emitted <= emitted + 1'b1;
      end else if (fin_go && op == spg_pkg::OP_FIN_LAST) begin
        emitted   <= emitted + 1'b1;
        exhausted <= 1'b1;
      end
      if (fin_go && (op == spg_pkg::OP_FIN_OK || op == spg_pkg::OP_FIN_LAST ||
                     op == spg_pkg::OP_FIN_BAD)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // index order registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_LEN; i++) begin
      if (rst || restart) begin
        idx_ord[i] <= IW'(i);
      end else if (iw_en && iw_addr == IW'(i)) begin
        idx_ord[i] <= iw_data;
      end
    end
  end

  // sorted character store
  always_ff @(posedge clk) begin
    if (op == spg_pkg::OP_LD_SHIFT && flags.ins_move) begin
      chars[ptr[IW-1:0]] <= crd;
    end else if (op == spg_pkg::OP_LD_PUT) begin
      chars[ptr[IW-1:0]] <= ch_q;
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    if (op == spg_pkg::OP_ACCEPT && cmd_valid) begin
      cmd_q <= command;
      ch_q  <= char_value;
    end
    case (op)
      spg_pkg::OP_LD_INIT:  ptr <= loaded;
      spg_pkg::OP_LD_SHIFT: begin
        if (flags.ins_move) begin
          ptr <= ptrm1;
        end
      end
      spg_pkg::OP_EM_INIT:  ptr <= '0;
      spg_pkg::OP_GATHER:   ptr <= ptr_inc;
      spg_pkg::OP_ST_INIT: begin
        p     <= nm1;
        b_val <= idx_rd;
      end
      spg_pkg::OP_ST_SCAN: begin
        if (flags.scan_cont) begin
          b_val <= idx_rd;
          p     <= pm1;
        end else begin
          piv <= idx_rd;
        end
      end
      spg_pkg::OP_Q_INIT:   q <= nm1;
      spg_pkg::OP_Q_SCAN: begin
        if (flags.q_cont) begin
          q <= q - 1'b1;
        end
      end
      spg_pkg::OP_REV_INIT: begin
        lo <= p;
        hi <= nm1;
      end
      spg_pkg::OP_REV_A:    tmp <= idx_rd;
      spg_pkg::OP_REV_C: begin
        lo <= lo + 1'b1;
        hi <= hi - 1'b1;
      end
      default: begin
      end
    endcase
  end

  // arrangement lanes
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_LEN; k++) begin
      if (op == spg_pkg::OP_EM_INIT) begin
        arr[8*k +: 8] <= '0;
      end else if (op == spg_pkg::OP_GATHER && ptr == CW'(k)) begin
        arr[8*k +: 8] <= crd;
      end
    end
  end

  assign arr_ext = {{spg_pkg::ARR_W{1'b0}}, arr};

  // result register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      case (op)
        spg_pkg::OP_FIN_OK, spg_pkg::OP_FIN_LAST: begin
          arrangement <= arr_ext[spg_pkg::ARR_W-1:0];
          rank        <= emitted + 1'b1;
          is_last     <= (op == spg_pkg::OP_FIN_LAST);
          valid_res   <= 1'b1;
        end
        spg_pkg::OP_FIN_BAD: begin
          arrangement <= '0;
          rank        <= '0;
          is_last     <= 1'b0;
          valid_res   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/spg_seq.sv =====
`default_nettype none

module spg_seq (
  input  wire                 clk,
  input  wire                 rst,
  input  spg_pkg::spg_flags_t flags,
  output spg_pkg::ucode_t     uword
);

  logic [spg_pkg::UPC_W-1:0] upc;
  logic [spg_pkg::UPC_W-1:0] upc_next;
  logic                      hit;

  assign uword = spg_pkg::rom_word(upc);

  always_comb begin
    unique case (uword.cond)
      spg_pkg::C_NEVER:       hit = 1'b0;
      spg_pkg::C_ALWAYS:      hit = 1'b1;
      spg_pkg::C_NO_TAKE:     hit = flags.no_take;
      spg_pkg::C_CMD_CLEAR:   hit = flags.cmd_clear;
      spg_pkg::C_CMD_LOAD:    hit = flags.cmd_load;
      spg_pkg::C_CMD_EMIT:    hit = flags.cmd_emit;
      spg_pkg::C_FULL:        hit = flags.full;
      spg_pkg::C_INS_MOVE:    hit = flags.ins_move;
      spg_pkg::C_NOT_READY:   hit = flags.not_ready;
      spg_pkg::C_GATHER_MORE: hit = flags.gather_more;
      spg_pkg::C_N_LT2:       hit = flags.n_lt2;
      spg_pkg::C_P_ZERO:      hit = flags.p_zero;
      spg_pkg::C_SCAN_CONT:   hit = flags.scan_cont;
      spg_pkg::C_Q_CONT:      hit = flags.q_cont;
      spg_pkg::C_LO_GE_HI:    hit = flags.lo_ge_hi;
      spg_pkg::C_OUT_BUSY:    hit = flags.out_busy;
      default:                hit = 1'b0;
    endcase
  end

  always_comb begin
    if (hit) begin
      upc_next = uword.target;
    end else if (uword.ret) begin
      upc_next = spg_pkg::U_IDLE;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= spg_pkg::U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire
